// File: hdl/beq_pkg.sv
// shared constants, types and word layouts of the biquad equalizer cascade
package beq_pkg;

    // filter shape
    localparam int NUM_STAGES      = 7;
    localparam int NUM_CHANNELS    = 2;
    localparam int SAMPLE_BITS     = 24;
    localparam int COEF_FRAC_BITS  = 28;
    localparam int COEFS_PER_STAGE = 5;

    // fixed field widths of the stream words
    localparam int REQ_W   = 1;
    localparam int CHAN_W  = 1;
    localparam int STAGE_W = 3;
    localparam int SEL_W   = 3;
    localparam int COEF_W  = 32;

    // datapath widths
    localparam int DELAY_W    = 40;
    localparam int SPLIT_BITS = 12;
    localparam int HI_W       = DELAY_W - SPLIT_BITS;
    localparam int PROD_W     = HI_W + COEF_W;
    localparam int FULL_W     = DELAY_W + COEF_W;
    localparam int TERM_W     = FULL_W - COEF_FRAC_BITS;
    localparam int ACC_W      = TERM_W + 2;
    localparam int IN_SHIFT   = 32 - SAMPLE_BITS;

    // storage sizes and index widths
    localparam int NUM_COEFS = NUM_STAGES * COEFS_PER_STAGE;
    localparam int NUM_DLY   = NUM_STAGES * NUM_CHANNELS;
    localparam int CADDR_W   = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
    localparam int DADDR_W   = (NUM_DLY > 1) ? $clog2(NUM_DLY) : 1;
    localparam int STG_CNT_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int SLOT_LAST = 2 * COEFS_PER_STAGE - 1;
    localparam int SLOT_W    = $clog2(2 * COEFS_PER_STAGE);

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QADDR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input word layout, lowest bit first
    localparam int SAMPLE_LSB  = 0;
    localparam int STAGE_LSB   = SAMPLE_LSB + SAMPLE_BITS;
    localparam int SEL_LSB     = STAGE_LSB + STAGE_W;
    localparam int VALUE_LSB   = SEL_LSB + SEL_W;
    localparam int IN_BITS     = VALUE_LSB + COEF_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_W  = REQ_W + CHAN_W;
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 1;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE,
        REQ_COEF
    } req_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_B0,
        SEL_B1,
        SEL_B2,
        SEL_A1,
        SEL_A2
    } coef_sel_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    typedef struct packed {
        req_t                      kind;
        logic [CHAN_W-1:0]         channel;
        logic [SAMPLE_BITS-1:0]    sample;
        logic [STAGE_W-1:0]        stage;
        coef_sel_t                 sel;
        logic [COEF_W-1:0]         value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

endpackage

// File: hdl/beq_front.sv
// input side: unpacks stream words, drops bad requests, feeds the queue
module beq_front
    import beq_pkg::*;
(
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [IN_TUSER_W-1:0] s_axis_tuser,
    input  logic                  q_full,
    output cmd_slot_t             push
);

    cmd_t cmd;
    logic keep;

    always_comb
    begin
        cmd.kind    = req_t'(s_axis_tuser[REQ_W-1:0]);
        cmd.channel = s_axis_tuser[REQ_W +: CHAN_W];
        cmd.sample  = s_axis_tdata[SAMPLE_LSB +: SAMPLE_BITS];
        cmd.stage   = s_axis_tdata[STAGE_LSB +: STAGE_W];
        cmd.sel     = coef_sel_t'(s_axis_tdata[SEL_LSB +: SEL_W]);
        cmd.value   = s_axis_tdata[VALUE_LSB +: COEF_W];
    end

    // bad coefficient addresses and unknown channels vanish here
    always_comb
    begin
        case (cmd.kind)
            REQ_COEF:
                keep = (int'(cmd.stage) < NUM_STAGES)
                    && (cmd.sel inside {SEL_B0, SEL_B1, SEL_B2, SEL_A1, SEL_A2});
            REQ_SAMPLE:
                keep = int'(cmd.channel) < NUM_CHANNELS;
            default:
                keep = 1'b0;
        endcase
    end

    assign s_axis_tready = !q_full;
    assign push.valid    = s_axis_tvalid && !q_full && keep;
    assign push.cmd      = cmd;

endmodule

// File: hdl/beq_fifo.sv
// short command queue between the front and back ends
module beq_fifo
    import beq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_slot_t push,
    output logic      full,
    output cmd_slot_t head,
    input  logic      pop
);

    cmd_t               mem [QUEUE_DEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (int'(count_reg) == QUEUE_DEPTH);
    assign do_push  = push.valid && !full;
    assign do_pop   = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// File: hdl/beq_back.sv
// back end: coefficient store, delay state and the shared multiply-accumulate sequencer
module beq_back
    import beq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_slot_t              head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   out_clip
);

    typedef struct packed {
        logic                 valid;
        coef_sel_t            term;
        logic                 half;
        logic [STG_CNT_W-1:0] stage;
    } tag_t;

    localparam int OSHIFT = IN_SHIFT;
    localparam logic signed [DELAY_W:0] RND =
        (OSHIFT > 0) ? ((DELAY_W + 1)'(1) <<< (OSHIFT - 1)) : '0;

    // sequencer
    bk_state_t            state_reg, state_next;
    logic [STG_CNT_W-1:0] stage_reg, stage_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 issue_reg, issue_next;
    logic                 start, coef_wr, done;

    // coefficient store
    logic [COEF_W-1:0]        coef_mem [NUM_COEFS];
    logic [NUM_COEFS-1:0]     coef_vld_reg;
    logic [COEF_W-1:0]        coef_q_reg;
    logic                     coef_hit_reg;
    logic                     coef_b0_reg;
    logic [CADDR_W-1:0]       raddr, waddr;
    coef_sel_t                issue_term;

    // delay state
    logic signed [DELAY_W-1:0] z1_reg [NUM_DLY];
    logic signed [DELAY_W-1:0] z2_reg [NUM_DLY];
    logic [DADDR_W-1:0]        didx;
    logic signed [DELAY_W-1:0] z1_rd, z2_rd;

    // datapath
    logic [CHAN_W-1:0]         chan_reg;
    logic signed [DELAY_W-1:0] x_reg, y_reg;
    logic signed [TERM_W-1:0]  tb1_reg, tb2_reg, term_reg;
    logic signed [PROD_W-1:0]  mul_reg, plo_reg;
    logic signed [FULL_W-1:0]  full;
    logic signed [COEF_W-1:0]  coef_eff;
    logic signed [DELAY_W-1:0] src;
    logic signed [HI_W-1:0]    part;
    tag_t                      tag0_reg, tag1_reg, tag2_reg;
    logic                      clip_reg;

    // accumulate and saturate
    logic signed [ACC_W-1:0]   term_ext, sum_y, sum_z1, sum_z2, acc;
    logic signed [DELAY_W-1:0] acc_sat;
    logic                      acc_ovf, sat_used, clip_now;
    logic                      set_y, cap_b1, cap_b2, wr_z1, wr_z2;

    // output rounding
    logic signed [DELAY_W:0]   rnd_sum, rnd_q;
    logic                      rnd_ovf;
    logic [SAMPLE_BITS-1:0]    rnd_out;

    logic                      out_valid_reg;
    logic [SAMPLE_BITS-1:0]    out_sample_reg;
    logic                      out_clip_reg;

    // state machine
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        start      = 1'b0;
        coef_wr    = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.cmd.kind == REQ_COEF)
                    begin
                        pop     = 1'b1;
                        coef_wr = 1'b1;
                    end
                    else if (!out_valid_reg || out_ready)
                    begin
                        pop        = 1'b1;
                        start      = 1'b1;
                        state_next = BK_RUN;
                    end
                end
            end
            BK_RUN:
            begin
                if (done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // issue counter: two multiplier passes per coefficient, five coefficients per stage
    always_comb
    begin
        stage_next = stage_reg;
        slot_next  = slot_reg;
        issue_next = issue_reg;
        if (start)
        begin
            stage_next = '0;
            slot_next  = '0;
            issue_next = 1'b1;
        end
        else if (issue_reg)
        begin
            if (int'(slot_reg) == SLOT_LAST)
            begin
                slot_next = '0;
                if (int'(stage_reg) == NUM_STAGES - 1)
                begin
                    issue_next = 1'b0;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                end
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            stage_reg <= '0;
            slot_reg  <= '0;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            slot_reg  <= slot_next;
            issue_reg <= issue_next;
        end
    end

    // coefficient read, registered the cycle before the multiplier uses it
    assign issue_term = coef_sel_t'(SEL_W'(slot_reg >> 1));
    assign raddr = CADDR_W'(int'(stage_reg) * COEFS_PER_STAGE + int'(issue_term));
    assign waddr = CADDR_W'(int'(head.cmd.stage) * COEFS_PER_STAGE + int'(head.cmd.sel));

    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            coef_mem[waddr] <= head.cmd.value;
        end
        coef_q_reg  <= coef_mem[raddr];
        coef_b0_reg <= (issue_term == SEL_B0);
    end

    // entries never written read as their reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            coef_hit_reg <= 1'b0;
            tag0_reg     <= '0;
            tag1_reg     <= '0;
            tag2_reg     <= '0;
        end
        else
        begin
            if (coef_wr)
            begin
                coef_vld_reg[waddr] <= 1'b1;
            end
            coef_hit_reg   <= coef_vld_reg[raddr];
            tag0_reg.valid <= issue_reg;
            tag0_reg.term  <= issue_term;
            tag0_reg.half  <= slot_reg[0];
            tag0_reg.stage <= stage_reg;
            tag1_reg       <= tag0_reg;
            tag2_reg.valid <= tag1_reg.valid && tag1_reg.half;
            tag2_reg.term  <= tag1_reg.term;
            tag2_reg.half  <= tag1_reg.half;
            tag2_reg.stage <= tag1_reg.stage;
        end
    end

    // multiplier: low 12 bits of the operand first, then the high part
    always_comb
    begin
        coef_eff = coef_hit_reg ? $signed(coef_q_reg) : (coef_b0_reg ? COEF_ONE : '0);
        src      = (tag0_reg.term inside {SEL_B0, SEL_B1, SEL_B2}) ? x_reg : y_reg;
        part     = tag0_reg.half ? $signed(src[DELAY_W-1:SPLIT_BITS])
                                 : $signed(HI_W'(src[SPLIT_BITS-1:0]));
    end

    assign full = (FULL_W'(mul_reg) <<< SPLIT_BITS) + FULL_W'(plo_reg);

    always_ff @(posedge clk)
    begin
        mul_reg <= part * coef_eff;
        if (tag1_reg.valid && !tag1_reg.half)
        begin
            plo_reg <= mul_reg;
        end
        if (tag1_reg.valid && tag1_reg.half)
        begin
            term_reg <= TERM_W'(full >>> COEF_FRAC_BITS);
        end
    end

    // accumulate step: each floored product joins its sum once both of its multiplier passes are done
    assign didx  = DADDR_W'(int'(tag2_reg.stage) * NUM_CHANNELS + int'(chan_reg));
    assign z1_rd = z1_reg[didx];
    assign z2_rd = z2_reg[didx];

    always_comb
    begin
        term_ext = ACC_W'(term_reg);
        sum_y    = term_ext + ACC_W'(z1_rd);
        sum_z1   = ACC_W'(tb1_reg) - term_ext + ACC_W'(z2_rd);
        sum_z2   = ACC_W'(tb2_reg) - term_ext;
        set_y    = 1'b0;
        cap_b1   = 1'b0;
        cap_b2   = 1'b0;
        wr_z1    = 1'b0;
        wr_z2    = 1'b0;
        acc      = sum_y;
        case (tag2_reg.term)
            SEL_B0:
            begin
                set_y = tag2_reg.valid;
            end
            SEL_B1:
            begin
                cap_b1 = tag2_reg.valid;
            end
            SEL_B2:
            begin
                cap_b2 = tag2_reg.valid;
            end
            SEL_A1:
            begin
                acc   = sum_z1;
                wr_z1 = tag2_reg.valid;
            end
            SEL_A2:
            begin
                acc   = sum_z2;
                wr_z2 = tag2_reg.valid;
            end
            default:
            begin
                acc = sum_y;
            end
        endcase
        acc_ovf  = !((&acc[ACC_W-1:DELAY_W-1]) || !(|acc[ACC_W-1:DELAY_W-1]));
        acc_sat  = acc_ovf ? (acc[ACC_W-1] ? {1'b1, {(DELAY_W-1){1'b0}}}
                                           : {1'b0, {(DELAY_W-1){1'b1}}})
                           : acc[DELAY_W-1:0];
        sat_used = set_y || wr_z1 || wr_z2;
        clip_now = clip_reg || (sat_used && acc_ovf);
        done     = wr_z2 && (int'(tag2_reg.stage) == NUM_STAGES - 1);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= $signed(DELAY_W'($signed(head.cmd.sample))) <<< IN_SHIFT;
            chan_reg <= head.cmd.channel;
        end
        else if (cap_b2)
        begin
            // last use of this stage's input is past, next stage takes y
            x_reg <= y_reg;
        end
        if (set_y)
        begin
            y_reg <= acc_sat;
        end
        if (cap_b1)
        begin
            tb1_reg <= term_reg;
        end
        if (cap_b2)
        begin
            tb2_reg <= term_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= 1'b0;
        end
        else if (start)
        begin
            clip_reg <= 1'b0;
        end
        else if (sat_used)
        begin
            clip_reg <= clip_now;
        end
    end

    // delay state, cleared per stage by a coefficient write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DLY; i++)
            begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
        end
        else if (coef_wr)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                z1_reg[DADDR_W'(int'(head.cmd.stage) * NUM_CHANNELS + c)] <= '0;
                z2_reg[DADDR_W'(int'(head.cmd.stage) * NUM_CHANNELS + c)] <= '0;
            end
        end
        else
        begin
            if (wr_z1)
            begin
                z1_reg[didx] <= acc_sat;
            end
            if (wr_z2)
            begin
                z2_reg[didx] <= acc_sat;
            end
        end
    end

    // round half up to the output width and clamp
    always_comb
    begin
        rnd_sum = $signed({y_reg[DELAY_W-1], y_reg}) + RND;
        rnd_q   = rnd_sum >>> OSHIFT;
        rnd_ovf = !((&rnd_q[DELAY_W:SAMPLE_BITS-1]) || !(|rnd_q[DELAY_W:SAMPLE_BITS-1]));
        rnd_out = rnd_ovf ? (rnd_q[DELAY_W] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                            : {1'b0, {(SAMPLE_BITS-1){1'b1}}})
                          : rnd_q[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_sample_reg <= rnd_out;
            out_clip_reg   <= clip_now || rnd_ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_clip   = out_clip_reg;

endmodule

// File: hdl/biquad_peaking_eq_cascade.sv
// top level of the seven-stage biquad equalizer cascade
//
//  channel | direction | tdata (lowest bit up)                          | tuser
//  s_axis  | in        | sample_in 24, stage_index 3, coef_select 3,    | req_type, channel
//          |           | coef_value 32, 2 zero pad bits                 |
//  m_axis  | out       | sample_out 24                                  | clipped
//
// a sample holds the back end through a start step, ten passes per stage of one 28x32
// multiplier (two per coefficient product), then a three-deep drain of the multiply and
// accumulate pipeline; the result word shows on the next cycle
// a coefficient write is done while the back end is idle and clears that stage's delays
// reset is asynchronous and active low; coefficients come up as b0 = 1.0, delays as zero
// the two-word queue keeps s_axis_tready high while a sample runs until two words wait; a new sample starts
// only once the previous result has left or is leaving the output register
module biquad_peaking_eq_cascade
    import beq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sample_in, stage_index, coef_select, coef_value
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // req_type, channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // sample_out
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // clipped
);

    cmd_slot_t              push;     // classified word from the front end
    cmd_slot_t              head;     // oldest queued word
    logic                   q_full;
    logic                   pop;
    logic [SAMPLE_BITS-1:0] out_sample;
    logic                   out_clip;

    // unpack and filter the incoming words
    beq_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push)
    );

    // decouples input acceptance from the long per-sample run
    beq_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    // coefficient writes and the filter run, with the output register
    beq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (out_sample),
        .out_clip   (out_clip)
    );

    // result word, zero padded to whole bytes
    assign m_axis_tdata = OUT_TDATA_W'(out_sample);
    assign m_axis_tuser = OUT_TUSER_W'(out_clip);

endmodule

// File: hdl/beq_checker.sv
// port-level checks of the equalizer cascade and their binding to the top level
module beq_checker
    import beq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // a stalled result word holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // no result right after reset, and the queue is open
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("block not quiet after reset");

    // a new result needs a whole sample run, so results never come back to back
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("second result one cycle after the first");

    // with no word offered the queue cannot fill, so an open input stays open
    a_ready_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tvalid && s_axis_tready |=> s_axis_tready)
        else $error("input stalled with no word offered");

endmodule

bind biquad_peaking_eq_cascade beq_checker u_beq_checker (.*);
